// ===== hw/rtl/rbfc_pkg.sv =====
// Shared types, sizes and constants of the RBF prototype classifier core.
// Used by the multiplier, the top level and the testbench. No dependencies.
`default_nettype none

package rbfc_pkg;

    localparam int IN_DIM      = 256;
    localparam int PROJ_DIM    = 16;
    localparam int NUM_PROTOS  = 32;
    localparam int NUM_CLASSES = 16;
    localparam int FRAC_BITS   = 16;

    localparam int PD_W     = (PROJ_DIM > 1) ? $clog2(PROJ_DIM) : 1;
    localparam int NC_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PROJ_AW  = $clog2(PROJ_DIM * IN_DIM);
    localparam int PROTO_AW = $clog2(PROJ_DIM * NUM_PROTOS);
    localparam int LW_AW    = $clog2(NUM_CLASSES * NUM_PROTOS);

    localparam int DATA_W    = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CFG_IDX_W = 8;

    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] GAMMA_RST = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_EN = 8'd1;

    typedef enum logic [2:0] {
        FUNC_PROJ   = 3'd0,
        FUNC_PROTO  = 3'd1,
        FUNC_LABEL  = 3'd2,
        FUNC_OFFSET = 3'd3,
        FUNC_SAMPLE = 3'd4
    } func_t;

    typedef enum logic [4:0] {
        S_IDLE, S_FEAT, S_OFS,
        S_DRD, S_DMUL, S_DACC,
        S_GAM, S_GSAT, S_XMUL, S_XRED, S_HMUL, S_HSUB, S_ESH,
        S_LRD, S_LMUL, S_LACC,
        S_MAX, S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         class_id;
        logic signed [31:0] best_score;
    } out_item_t;

    // Horner coefficients of 2^-u in Q30: 2^30 (ln2)^k / k!
    function automatic logic [31:0] exp_coef(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd0:    c = 32'd1073741824;
            3'd1:    c = 32'd744261118;
            3'd2:    c = 32'd257941248;
            3'd3:    c = 32'd59597083;
            3'd4:    c = 32'd10327388;
            3'd5:    c = 32'd1431680;
            3'd6:    c = 32'd165394;
            default: c = 32'd16378;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(PROD_W-32){1'b0}}, 32'h7FFF_FFFF}))
            r = 32'sh7FFF_FFFF;
        else if (v < $signed({{(PROD_W-32){1'b1}}, 32'h8000_0000}))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rbfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rbfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rbfc_mul.sv =====
// Shared signed 33x33 multiplier with registered product.
// Depends on rbfc_pkg.
`default_nettype none

module rbfc_mul (
    input  wire logic                               clk,
    input  wire logic signed [rbfc_pkg::MUL_W-1:0]  a,
    input  wire logic signed [rbfc_pkg::MUL_W-1:0]  b,
    output      logic signed [rbfc_pkg::PROD_W-1:0] p
);
    import rbfc_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/prototype_rbf_classifier_core.sv =====
// Top level of the RBF prototype classifier: table RAMs, sequencer, shared multiplier.
// Depends on rbfc_pkg, rbfc_ram, rbfc_mul.
//
//  channel   direction  handshake            beat
//  in        sink       in_valid / in_stall  in_data (in_item_t)
//  out       source     out_valid / out_stall out_data (out_item_t)
//  cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A table load is written as it is accepted. A feature sample makes one pass of
// PROJ_DIM products through the shared multiplier. A last sample then adds the offset
// pass, per prototype the distance, exp and label score passes (the exp polynomial
// is skipped when the kernel underflows to zero), then argmax and result. Input is
// stalled while any item is in work. Reset clears control, accumulators and scores;
// table RAMs hold garbage until loaded. The result register frees the sequencer once
// out accepts it.
`default_nettype none

module prototype_rbf_classifier_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire rbfc_pkg::in_item_t                 in_data,
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      rbfc_pkg::out_item_t                out_data,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [rbfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data
);
    import rbfc_pkg::*;

    state_t state_reg, state_next;

    logic [31:0] gamma_reg;
    logic        ofs_en_reg;
    in_item_t    item_reg, item_next;

    logic signed [31:0] acc_reg   [PROJ_DIM];
    logic signed [31:0] acc_next  [PROJ_DIM];
    logic signed [31:0] score_reg [NUM_CLASSES];
    logic signed [31:0] score_next[NUM_CLASSES];
    logic signed [31:0] off_reg   [PROJ_DIM];

    logic [7:0]      j_reg, j_next;
    logic [7:0]      i_reg, i_next;
    logic [2:0]      k_reg, k_next;
    logic [4:0]      n_reg, n_next;
    logic [29:0]     u_reg, u_next;
    logic [31:0]     dist_reg, dist_next;
    logic [31:0]     p_reg, p_next;
    logic [31:0]     e_reg, e_next;
    logic signed [31:0] best_reg, best_next;
    logic [7:0]      best_id_reg, best_id_next;
    logic            done_reg, done_next;
    logic            v1_reg, v1_next, v2_reg, v2_next;
    logic [PD_W-1:0] idx1_reg, idx1_next, idx2_reg, idx2_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic                     accept;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                proj_we, proto_we, lw_we;
    logic [PROJ_AW-1:0]  proj_waddr, proj_raddr;
    logic [PROTO_AW-1:0] proto_waddr, proto_raddr;
    logic [LW_AW-1:0]    lw_waddr, lw_raddr;
    logic [31:0]         proj_rdata, proto_rdata, lw_rdata;

    logic row_pd_ok, row_nc_ok, col_in_ok, col_np_ok;

    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [64:0]        dsum;
    logic [32:0]        y;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign row_pd_ok = {1'b0, in_data.row} < 9'(PROJ_DIM);
    assign row_nc_ok = {1'b0, in_data.row} < 9'(NUM_CLASSES);
    assign col_in_ok = {1'b0, in_data.col} < 9'(IN_DIM);
    assign col_np_ok = {1'b0, in_data.col} < 9'(NUM_PROTOS);

    assign proj_we  = accept && in_data.func == FUNC_PROJ   && row_pd_ok && col_in_ok;
    assign proto_we = accept && in_data.func == FUNC_PROTO  && row_pd_ok && col_np_ok;
    assign lw_we    = accept && in_data.func == FUNC_LABEL  && row_nc_ok && col_np_ok;

    assign proj_waddr  = PROJ_AW'(int'(in_data.row) * IN_DIM + int'(in_data.col));
    assign proto_waddr = PROTO_AW'(int'(in_data.row) * NUM_PROTOS + int'(in_data.col));
    assign lw_waddr    = LW_AW'(int'(in_data.row) * NUM_PROTOS + int'(in_data.col));

    assign proj_raddr  = PROJ_AW'(int'(j_reg[PD_W-1:0]) * IN_DIM + int'(item_reg.col));
    assign proto_raddr = PROTO_AW'(int'(j_reg[PD_W-1:0]) * NUM_PROTOS + int'(i_reg));
    assign lw_raddr    = LW_AW'(int'(j_reg[NC_W-1:0]) * NUM_PROTOS + int'(i_reg));

    rbfc_ram #(.WIDTH(DATA_W), .DEPTH(PROJ_DIM * IN_DIM)) u_proj_ram (
        .clk(clk), .we(proj_we), .waddr(proj_waddr), .wdata(in_data.value),
        .raddr(proj_raddr), .rdata(proj_rdata)
    );

    rbfc_ram #(.WIDTH(DATA_W), .DEPTH(PROJ_DIM * NUM_PROTOS)) u_proto_ram (
        .clk(clk), .we(proto_we), .waddr(proto_waddr), .wdata(in_data.value),
        .raddr(proto_raddr), .rdata(proto_rdata)
    );

    rbfc_ram #(.WIDTH(DATA_W), .DEPTH(NUM_CLASSES * NUM_PROTOS)) u_lw_ram (
        .clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(in_data.value),
        .raddr(lw_raddr), .rdata(lw_rdata)
    );

    rbfc_mul u_mul (
        .clk(clk), .a(mul_a), .b(mul_b), .p(prod)
    );

    // config registers and the small offset table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg  <= GAMMA_RST;
            ofs_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_GAMMA)
                gamma_reg <= cfg_data;
            else if (cfg_index == CFG_OFS_EN)
                ofs_en_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.func == FUNC_OFFSET && row_pd_ok)
            off_reg[in_data.row[PD_W-1:0]] <= in_data.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            done_reg      <= 1'b0;
            j_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            for (int q = 0; q < PROJ_DIM; q++)
                acc_reg[q] <= '0;
            for (int q = 0; q < NUM_CLASSES; q++)
                score_reg[q] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            done_reg      <= done_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            score_reg     <= score_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx1_reg     <= idx1_next;
        idx2_reg     <= idx2_next;
        n_reg        <= n_next;
        u_reg        <= u_next;
        dist_reg     <= dist_next;
        p_reg        <= p_next;
        e_reg        <= e_next;
        best_reg     <= best_next;
        best_id_reg  <= best_id_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        score_next     = score_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        u_next         = u_reg;
        dist_next      = dist_reg;
        p_next         = p_reg;
        e_next         = e_reg;
        best_next      = best_reg;
        best_id_next   = best_id_reg;
        done_next      = done_reg;
        v1_next        = 1'b0;
        v2_next        = 1'b0;
        idx1_next      = idx1_reg;
        idx2_next      = idx2_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        diff           = 33'(acc_reg[j_reg[PD_W-1:0]]) - 33'($signed(proto_rdata));
        mag            = diff[32] ? 32'(-diff) : diff[31:0];
        dsum           = 65'(dist_reg) + 65'(prod[63:FRAC_BITS]);
        y              = prod[62:30];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.func == FUNC_SAMPLE)
                begin
                    item_next = in_data;
                    j_next    = '0;
                    done_next = 1'b0;
                    if (col_in_ok)
                        state_next = S_FEAT;
                    else if (in_data.last)
                        state_next = S_OFS;
                end
            end

            // three-stage pass: read weight, multiply, accumulate
            S_FEAT:
            begin
                if (!done_reg)
                begin
                    v1_next   = 1'b1;
                    idx1_next = j_reg[PD_W-1:0];
                    if (j_reg == 8'(PROJ_DIM - 1))
                        done_next = 1'b1;
                    else
                        j_next = j_reg + 8'd1;
                end
                mul_a     = 33'($signed(proj_rdata));
                mul_b     = 33'(item_reg.value);
                v2_next   = v1_reg;
                idx2_next = idx1_reg;
                if (v2_reg)
                    acc_next[idx2_reg] =
                        sat32(PROD_W'(acc_reg[idx2_reg]) + (prod >>> FRAC_BITS));
                if (done_reg && !v1_reg && !v2_reg)
                begin
                    j_next     = '0;
                    state_next = item_reg.last ? S_OFS : S_IDLE;
                end
            end

            S_OFS:
            begin
                if (ofs_en_reg)
                    acc_next[j_reg[PD_W-1:0]] = sat32(PROD_W'(acc_reg[j_reg[PD_W-1:0]])
                                               - PROD_W'(off_reg[j_reg[PD_W-1:0]]));
                if (j_reg == 8'(PROJ_DIM - 1))
                begin
                    j_next     = '0;
                    i_next     = '0;
                    dist_next  = '0;
                    state_next = S_DRD;
                end
                else
                    j_next = j_reg + 8'd1;
            end

            S_DRD:
                state_next = S_DMUL;

            S_DMUL:
            begin
                mul_a      = $signed({1'b0, mag});
                mul_b      = $signed({1'b0, mag});
                state_next = S_DACC;
            end

            S_DACC:
            begin
                dist_next = (|dsum[64:32]) ? 32'hFFFF_FFFF : dsum[31:0];
                if (j_reg == 8'(PROJ_DIM - 1))
                begin
                    j_next     = '0;
                    state_next = S_GAM;
                end
                else
                begin
                    j_next     = j_reg + 8'd1;
                    state_next = S_DRD;
                end
            end

            S_GAM:
            begin
                mul_a      = $signed({1'b0, gamma_reg});
                mul_b      = $signed({1'b0, dist_reg});
                state_next = S_GSAT;
            end

            S_GSAT:
            begin
                dist_next  = (|prod[PROD_W-1:FRAC_BITS+32]) ? 32'hFFFF_FFFF
                                                            : prod[FRAC_BITS+31:FRAC_BITS];
                state_next = S_XMUL;
            end

            S_XMUL:
            begin
                mul_a      = $signed({1'b0, dist_reg});
                mul_b      = $signed({1'b0, LOG2E_Q30});
                state_next = S_XRED;
            end

            // y = x log2(e); integer part scales (above FRAC_BITS the kernel is zero), fraction goes to the polynomial
            S_XRED:
            begin
                if ((y >> FRAC_BITS) > 33'(FRAC_BITS))
                begin
                    e_next     = '0;
                    j_next     = '0;
                    state_next = S_LRD;
                end
                else
                begin
                    n_next     = y[FRAC_BITS+4:FRAC_BITS];
                    u_next     = 30'(y[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
                    p_next     = exp_coef(3'd7);
                    k_next     = 3'd6;
                    state_next = S_HMUL;
                end
            end

            S_HMUL:
            begin
                mul_a      = $signed({1'b0, p_reg});
                mul_b      = $signed({3'b000, u_reg});
                state_next = S_HSUB;
            end

            S_HSUB:
            begin
                p_next = exp_coef(k_reg) - prod[61:30];
                if (k_reg == 3'd0)
                    state_next = S_ESH;
                else
                begin
                    k_next     = k_reg - 3'd1;
                    state_next = S_HMUL;
                end
            end

            S_ESH:
            begin
                e_next     = p_reg >> (6'(30 - FRAC_BITS) + 6'(n_reg));
                j_next     = '0;
                state_next = S_LRD;
            end

            S_LRD:
                state_next = S_LMUL;

            S_LMUL:
            begin
                mul_a      = 33'($signed(lw_rdata));
                mul_b      = $signed({1'b0, e_reg});
                state_next = S_LACC;
            end

            S_LACC:
            begin
                score_next[j_reg[NC_W-1:0]] =
                    sat32(PROD_W'(score_reg[j_reg[NC_W-1:0]]) + (prod >>> FRAC_BITS));
                if (j_reg == 8'(NUM_CLASSES - 1))
                begin
                    j_next = '0;
                    if (i_reg == 8'(NUM_PROTOS - 1))
                        state_next = S_MAX;
                    else
                    begin
                        i_next     = i_reg + 8'd1;
                        dist_next  = '0;
                        state_next = S_DRD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 8'd1;
                    state_next = S_LRD;
                end
            end

            // strict greater-than keeps the lowest index on ties
            S_MAX:
            begin
                if (j_reg == 8'd0 || score_reg[j_reg[NC_W-1:0]] > best_reg)
                begin
                    best_next    = score_reg[j_reg[NC_W-1:0]];
                    best_id_next = j_reg;
                end
                if (j_reg == 8'(NUM_CLASSES - 1))
                begin
                    j_next     = '0;
                    state_next = S_OUT;
                end
                else
                    j_next = j_reg + 8'd1;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.class_id   = best_id_reg;
                    out_data_next.best_score = best_reg;
                    for (int q = 0; q < PROJ_DIM; q++)
                        acc_next[q] = '0;
                    for (int q = 0; q < NUM_CLASSES; q++)
                        score_next[q] = '0;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // a result beat only appears from the result state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat without scoring pass");

    // exponent scale stays within the Q30 shift range
    a_exp_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ESH) |-> (n_reg <= 5'(FRAC_BITS)))
        else $error("exp scale out of range");

    // the first accumulator and the first score are clear once a result is issued
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && state_next == S_IDLE)
            |=> (acc_reg[0] == 32'sd0 && score_reg[0] == 32'sd0))
        else $error("state not cleared after result");

    // multiply pipeline stage 2 only follows stage 1
    a_feat_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("feature pipeline out of order");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for prototype_rbf_classifier_core: it loads a model, streams
// feature vectors and checks every class result against a fixed-point predictor.
// Depends on rbfc_pkg and the core RTL.
`timescale 1ns / 1ps

import rbfc_pkg::*;

class proto_scoreboard;
    logic [31:0]        gamma_sq;
    bit                 ofs_en;
    logic signed [31:0] proj_w   [PROJ_DIM][IN_DIM];
    logic signed [31:0] proto_v  [PROJ_DIM][NUM_PROTOS];
    logic signed [31:0] label_w  [NUM_CLASSES][NUM_PROTOS];
    logic signed [31:0] ofs_v    [PROJ_DIM];
    logic signed [31:0] proj_acc [PROJ_DIM];
    logic signed [31:0] scores   [NUM_CLASSES];
    out_item_t          expected_classes[$];
    int                 mismatches;
    int                 results_seen;
    int                 vectors;

    function new();
        gamma_sq     = GAMMA_RST;
        ofs_en       = 0;
        mismatches   = 0;
        results_seen = 0;
        vectors      = 0;
        foreach (proj_acc[j]) proj_acc[j] = 0;
        foreach (scores[j]) scores[j] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        if (idx == CFG_GAMMA)
            gamma_sq = data;
        else if (idx == CFG_OFS_EN)
            ofs_en = data[0];
    endfunction

    function logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // exp(-x) via 2^-(x log2 e), Horner in Q30, scaled to Q16
    function logic [31:0] neg_exp(logic [63:0] x);
        logic [63:0] coef [8];
        logic [63:0] y, n, u, p;
        coef = '{64'd1073741824, 64'd744261118, 64'd257941248, 64'd59597083,
                 64'd10327388, 64'd1431680, 64'd165394, 64'd16378};
        y = (x * 64'd1549082005) >> 30;
        n = y >> FRAC_BITS;
        if (n > FRAC_BITS)
            return 0;
        u = (y & ((64'd1 << FRAC_BITS) - 1)) << (30 - FRAC_BITS);
        p = coef[7];
        for (int k = 6; k >= 0; k--)
            p = coef[k] - ((p * u) >> 30);
        p = p >> (30 - FRAC_BITS + n);
        return p[31:0];
    endfunction

    function out_item_t classify();
        logic signed [31:0] pv [PROJ_DIM];
        logic signed [63:0] t, z, add;
        logic [63:0]        m, dsq, x;
        logic [31:0]        e;
        out_item_t          r;
        foreach (pv[j])
            pv[j] = clamp32(64'(proj_acc[j]) - (ofs_en ? 64'(ofs_v[j]) : 64'sd0));
        for (int i = 0; i < NUM_PROTOS; i++)
        begin
            dsq = 0;
            for (int j = 0; j < PROJ_DIM; j++)
            begin
                t = 64'(pv[j]) - 64'(proto_v[j][i]);
                m = (t < 0) ? -t : t;
                dsq = dsq + ((m * m) >> FRAC_BITS);
                if (dsq > 64'hFFFF_FFFF) dsq = 64'hFFFF_FFFF;
            end
            x = (64'(gamma_sq) * dsq) >> FRAC_BITS;
            if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
            e = neg_exp(x);
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                z = 64'(label_w[c][i]);
                add = (z * $signed({32'd0, e})) >>> FRAC_BITS;
                scores[c] = clamp32(64'(scores[c]) + add);
            end
        end
        r.class_id   = 0;
        r.best_score = scores[0];
        for (int c = 1; c < NUM_CLASSES; c++)
            if (scores[c] > r.best_score)
            begin
                r.best_score = scores[c];
                r.class_id   = 8'(c);
            end
        foreach (proj_acc[j]) proj_acc[j] = 0;
        foreach (scores[c]) scores[c] = 0;
        return r;
    endfunction

    function void note_item(in_item_t it);
        logic signed [63:0] add;
        case (it.func)
            FUNC_PROJ:
                if (it.row < PROJ_DIM) proj_w[it.row][it.col] = it.value;
            FUNC_PROTO:
                if (it.row < PROJ_DIM && it.col < NUM_PROTOS) proto_v[it.row][it.col] = it.value;
            FUNC_LABEL:
                if (it.row < NUM_CLASSES && it.col < NUM_PROTOS)
                    label_w[it.row][it.col] = it.value;
            FUNC_OFFSET:
                if (it.row < PROJ_DIM) ofs_v[it.row] = it.value;
            FUNC_SAMPLE:
            begin
                for (int j = 0; j < PROJ_DIM; j++)
                begin
                    add = (64'(proj_w[j][it.col]) * 64'(it.value)) >>> FRAC_BITS;
                    proj_acc[j] = clamp32(64'(proj_acc[j]) + add);
                end
                if (it.last)
                begin
                    expected_classes.push_back(classify());
                    vectors++;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        results_seen++;
        if (expected_classes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result class %0d score %0d",
                         got.class_id, got.best_score);
            return;
        end
        want = expected_classes.pop_front();
        if (got.class_id !== want.class_id || got.best_score !== want.best_score)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d: class exp %0d got %0d, score exp %0d got %0d",
                         results_seen, want.class_id, got.class_id,
                         want.best_score, got.best_score);
        end
    endfunction
endclass

module tb_top;
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    proto_scoreboard sb;
    int items_sent;
    int burst_left;
    int hold_reqs;
    int hold_done;
    int used_cols [32];

    prototype_rbf_classifier_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: stall pattern changes at random, plus long hold-offs
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_data);
            if (hold_reqs != hold_done)
            begin
                hold_done = hold_reqs;
                hold_left = 6000;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (mode == 0)
                out_stall <= 1'b0;
            else if (mode == 1)
                out_stall <= ($urandom_range(0, 1) == 1);
            else
                out_stall <= ($urandom_range(0, 7) != 0);
        end
    end

    function automatic in_item_t mk(int f, int r, int c, logic [31:0] v, int l);
        in_item_t it;
        it.func  = 3'(f);
        it.row   = 8'(r);
        it.col   = 8'(c);
        it.value = v;
        it.last  = 1'(l);
        return it;
    endfunction

    function automatic logic [31:0] small_val(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_item(in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // sender pauses until every result is back, then lets trailing loads settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_classes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_vector(int len, bit wide);
        logic [31:0] v;
        for (int k = 0; k < len; k++)
        begin
            v = wide ? $urandom() : small_val(65536);
            send_item(mk(FUNC_SAMPLE, $urandom_range(0, 255),
                         used_cols[$urandom_range(0, 31)], v, k == len - 1));
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_vector($urandom_range(1, 6), $urandom_range(0, 9) == 0);
        else if (pick < 78)
            send_item(mk(FUNC_PROJ, $urandom_range(0, PROJ_DIM - 1),
                         used_cols[$urandom_range(0, 31)], small_val(32768),
                         $urandom_range(0, 1)));
        else if (pick < 84)
            send_item(mk(FUNC_PROTO, $urandom_range(0, PROJ_DIM - 1),
                         $urandom_range(0, NUM_PROTOS - 1), small_val(98304), 0));
        else if (pick < 90)
            send_item(mk(FUNC_LABEL, $urandom_range(0, NUM_CLASSES - 1),
                         $urandom_range(0, NUM_PROTOS - 1),
                         ($urandom_range(0, 7) == 0) ? $urandom() : small_val(131072), 0));
        else if (pick < 93)
            send_item(mk(FUNC_OFFSET, $urandom_range(0, PROJ_DIM - 1), $urandom_range(0, 255),
                         small_val(65536), $urandom_range(0, 1)));
        else if (pick < 96)
            send_item(mk($urandom_range(5, 7), $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom(), $urandom_range(0, 1)));
        else
            // out-of-range loads
            send_item(mk($urandom_range(0, 3), $urandom_range(PROJ_DIM, 255),
                         $urandom_range(NUM_PROTOS, 255), $urandom(), $urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [31:0] gammas [4];
        bit          ofs    [4];
        sb = new();
        items_sent = 0;
        burst_left = 0;
        hold_reqs = 0;
        hold_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int k = 0; k < 16; k++)
        begin
            used_cols[k] = k;
            used_cols[16 + k] = 240 + k;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // model load: every table entry the vectors will touch
        foreach (used_cols[k])
            for (int j = 0; j < PROJ_DIM; j++)
                send_item(mk(FUNC_PROJ, j, used_cols[k], small_val(32768), 0));
        for (int i = 0; i < NUM_PROTOS; i++)
            for (int j = 0; j < PROJ_DIM; j++)
                send_item(mk(FUNC_PROTO, j, i, small_val(98304), 0));
        for (int i = 0; i < NUM_PROTOS; i++)
            for (int c = 0; c < NUM_CLASSES; c++)
                send_item(mk(FUNC_LABEL, c, i, small_val(131072), 0));
        for (int j = 0; j < PROJ_DIM; j++)
            send_item(mk(FUNC_OFFSET, j, 0, small_val(65536), 0));

        // directed: reset gamma, ignored codes, out-of-range loads, last on loads
        send_vector(1, 0);
        send_item(mk(3'd5, 255, 255, 32'hFFFF_FFFF, 1));
        send_item(mk(3'd6, 0, 0, 32'h0, 0));
        send_item(mk(3'd7, 170, 85, 32'h5555_AAAA, 1));
        send_item(mk(FUNC_PROJ, PROJ_DIM, 3, 32'h7FFF_FFFF, 1));
        send_item(mk(FUNC_PROTO, 2, NUM_PROTOS, 32'h8000_0000, 0));
        send_item(mk(FUNC_LABEL, NUM_CLASSES, 0, 32'h7FFF_FFFF, 0));
        send_item(mk(FUNC_OFFSET, 255, 0, 32'h8000_0000, 1));
        // saturation of projected accumulators at both ends
        send_item(mk(FUNC_PROJ, 0, 255, 32'h7FFF_FFFF, 1));
        send_item(mk(FUNC_PROJ, 1, 255, 32'h8000_0000, 0));
        send_item(mk(FUNC_SAMPLE, 0, 255, 32'h7FFF_FFFF, 0));
        send_item(mk(FUNC_SAMPLE, 0, 255, 32'h7FFF_FFFF, 1));
        send_item(mk(FUNC_SAMPLE, 255, 255, 32'h8000_0000, 1));
        send_item(mk(FUNC_PROJ, 0, 255, 32'h0000_8000, 0));
        send_item(mk(FUNC_PROJ, 1, 255, 32'hFFFF_8000, 0));
        send_item(mk(FUNC_SAMPLE, 0, 0, 32'h0, 1));
        drain();

        // gamma zero makes every kernel 1.0: equal saturated labels force a tie
        write_reg(CFG_GAMMA, 32'd0);
        write_reg(CFG_OFS_EN, 32'd1);
        write_reg(8'd2, 32'hFFFF_FFFF);
        for (int i = 0; i < NUM_PROTOS; i++)
        begin
            send_item(mk(FUNC_LABEL, 3, i, 32'h7FFF_FFFF, 0));
            send_item(mk(FUNC_LABEL, 5, i, 32'h7FFF_FFFF, 0));
        end
        send_vector(2, 0);
        send_vector(1, 1);
        drain();

        gammas = '{32'd3000, 32'hFFFF_FFFF, 32'd0, 32'd0};
        ofs    = '{1'b1, 1'b0, 1'b1, 1'b0};
        gammas[3] = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(1, 20000);
        ofs[3] = 1'($urandom_range(0, 1));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_GAMMA, gammas[ph]);
            write_reg(CFG_OFS_EN, {31'd0, ofs[ph]});
            if (ph == 0)
            begin
                // receiver holds off while the sender keeps offering
                hold_reqs++;
                send_vector(2, 0);
                repeat (8) random_item();
            end
            while (sb.vectors < 30 + 15 * ph || items_sent < 1700 + 50 * ph)
                random_item();
            drain();
        end
        // small random gamma, back to the reset value afterwards
        write_reg(CFG_GAMMA, $urandom_range(500, 8000));
        while (sb.vectors < 100)
            random_item();
        drain();
        write_reg(CFG_GAMMA, GAMMA_RST);
        repeat (10) random_item();
        drain();
        repeat (200) @(posedge clk);

        $display("Run: %0d input beats, %0d class results checked, %0d mismatches.",
                 items_sent, sb.results_seen, sb.mismatches);
        $display("Gamma swept from zero to full scale, offsets on and off.");
        if (sb.mismatches == 0 && sb.expected_classes.size() == 0)
            $display("CHECK OK");
        else
        begin
            if (sb.expected_classes.size() != 0)
                $display("ERROR: %0d results never arrived", sb.expected_classes.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
